// ===== sv/aie_pkg.sv =====
// ----------------------------------------------------------------------------
// aie_pkg
// Shared types, constants and checksum helper of the ARP/ICMP echo responder.
// ----------------------------------------------------------------------------
`default_nettype none

package aie_pkg;

  localparam int CacheEntriesDef = 8;
  localparam int HdrLen          = 42;
  localparam int QueueDepthDef   = 4;
  localparam logic [5:0] ArpLastIdx  = 6'd41;
  localparam logic [5:0] EchoLastIdx = 6'd61;
  localparam logic [31:0] OwnIpRst   = 32'h0A00_020F;
  localparam logic [15:0] EthArp     = 16'h0806;
  localparam logic [15:0] EthIpv4    = 16'h0800;
  localparam logic [19:0] IpHdrConst = 20'h0D765;
  localparam logic [19:0] IcmpConst  = 20'h6A0A4;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_ARP      = 2'd1,
    KIND_ECHO_REQ = 2'd2,
    KIND_ECHO_RPL = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_ARP  = 2'd1,
    RPL_ECHO = 2'd2
  } reply_e;

  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SEND = 1'b1
  } back_state_e;

  typedef struct packed {
    reply_e      reply;
    kind_e       kind;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic        hit;
    logic [47:0] mac;
    logic [31:0] peer_ip;
    logic [15:0] ip_ck;
    logic [15:0] icmp_ck;
  } cmd_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        is_last;
    kind_e       frame_kind;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
  } res_t;

  function automatic logic [15:0] ck_fold(input logic [19:0] s);
    logic [16:0] t;
    logic [15:0] u;
    t = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    u = t[15:0] + {15'b0, t[16]};
    return ~u;
  endfunction

endpackage

`default_nettype wire

// ===== sv/arp_icmp_echo_responder.sv =====
// ----------------------------------------------------------------------------
// arp_icmp_echo_responder
// ARP and ICMP echo responder with an ARP cache and lookup port.
// ----------------------------------------------------------------------------
// Input queue side: push/full carries either a received frame byte (opcode 0,
// rx_byte, rx_last) or a cache lookup (opcode 1, query_ip). Bytes are taken
// one per cycle while full is low; full rises only when the command queue
// between classifier and reply generator is full.
// Result queue side: empty/pop. A frame gives results only on its last byte:
// one status item, or a 42-byte ARP reply or 62-byte echo reply, one item per
// cycle while pop is high. A lookup gives one item with hit and MAC.
// Order: a status or lookup item passes the command queue and then the output
// register; a reply passes the queue, the BK_SEND state and the output
// register, and streams at one item per cycle while pop is high, from the
// single reply byte generator.
// When pop stays low the output register holds, then the queue fills, then
// full stops the input. Reset clears the byte count, cache valid bits, the
// queue and the registers (own IP 10.0.2.15, own MAC 0).
// APB: own_ip at 0x0, own_mac at 0x8, 64-bit data; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_icmp_echo_responder import aie_pkg::*; #(
  parameter int CacheEntries = CacheEntriesDef,
  parameter int QueueDepth   = QueueDepthDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire         opcode_i,
  input  wire  [7:0]  rx_byte_i,
  input  wire         rx_last_i,
  input  wire  [31:0] query_ip_i,
  output logic        empty,
  input  wire         pop,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        is_last_o,
  output logic [1:0]  frame_kind_o,
  output logic [15:0] echo_id_o,
  output logic [15:0] echo_seq_o,
  output logic        lookup_hit_o,
  output logic [47:0] lookup_mac_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic        accept, q_push, q_pop, q_full, q_empty, out_empty;
  cmd_t        q_cmd, q_head;
  res_t        res;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? {16'b0, own_mac_q} : {32'b0, own_ip_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= OwnIpRst;
      own_mac_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3]) begin
        own_mac_q <= pwdata[47:0];
      end else begin
        own_ip_q <= pwdata[31:0];
      end
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  aie_front #(.CacheEntries(CacheEntries)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .rx_byte_i  (rx_byte_i),
    .rx_last_i  (rx_last_i),
    .query_ip_i (query_ip_i),
    .own_ip_i   (own_ip_q),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  aie_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_cmd),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  aie_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (q_head),
    .q_empty_i (q_empty),
    .own_ip_i  (own_ip_q),
    .own_mac_i (own_mac_q),
    .pop_i     (pop),
    .q_pop_o   (q_pop),
    .empty_o   (out_empty),
    .res_o     (res)
  );

  assign empty        = out_empty;
  assign tx_valid_o   = res.tx_valid;
  assign tx_byte_o    = res.tx_byte;
  assign is_last_o    = res.is_last;
  assign frame_kind_o = res.frame_kind;
  assign echo_id_o    = res.echo_id;
  assign echo_seq_o   = res.echo_seq;
  assign lookup_hit_o = res.lookup_hit;
  assign lookup_mac_o = res.lookup_mac;

endmodule

`default_nettype wire

// ===== sv/aie_fifo.sv =====
// ----------------------------------------------------------------------------
// aie_fifo
// Short command queue between the frame classifier and the reply generator.
// ----------------------------------------------------------------------------
`default_nettype none

module aie_fifo import aie_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push_i,
  input  wire cmd_t data_i,
  input  wire       pop_i,
  output cmd_t      head_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== sv/aie_front.sv =====
// ----------------------------------------------------------------------------
// aie_front
// Collects frame headers, classifies frames, runs the ARP cache, queues work.
// ----------------------------------------------------------------------------
`default_nettype none

module aie_front import aie_pkg::*; #(
  parameter int CacheEntries = CacheEntriesDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         accept_i,
  input  wire         opcode_i,
  input  wire  [7:0]  rx_byte_i,
  input  wire         rx_last_i,
  input  wire  [31:0] query_ip_i,
  input  wire  [31:0] own_ip_i,
  output logic        q_push_o,
  output cmd_t        q_cmd_o
);

  localparam int IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;

  logic [5:0]  byte_cnt_q;
  logic [7:0]  hdr_q   [HdrLen];
  logic [7:0]  hv      [HdrLen];
  logic        cvalid_q [CacheEntries];
  logic [31:0] cip_q    [CacheEntries];
  logic [47:0] cmac_q   [CacheEntries];

  logic [5:0]  n;
  logic [15:0] eth, arp_op, idv, seqv;
  logic [31:0] arp_sip, arp_tip, ip_src, ip_dst, learn_ip;
  logic [47:0] arp_sha, eth_src, learn_mac, lk_mac, mac_f;
  logic        is_op_lookup, frame_end, is_arp, is_icmp, learn;
  logic        m_found, f_found, lk_found;
  logic [IdxW-1:0] m_idx, f_idx, slot;
  kind_e       kind;
  reply_e      rpl;

  always_comb begin
    for (int i = 0; i < HdrLen; i++) begin
      hv[i] = (byte_cnt_q == 6'(i)) ? rx_byte_i : hdr_q[i];
    end
  end

  assign is_op_lookup = (op_e'(opcode_i) == OP_LOOKUP);
  assign frame_end    = accept_i && !is_op_lookup && rx_last_i;
  assign n            = (byte_cnt_q == 6'd63) ? 6'd63 : byte_cnt_q + 6'd1;

  assign eth     = {hv[12], hv[13]};
  assign arp_op  = {hv[20], hv[21]};
  assign arp_sha = {hv[22], hv[23], hv[24], hv[25], hv[26], hv[27]};
  assign arp_sip = {hv[28], hv[29], hv[30], hv[31]};
  assign arp_tip = {hv[38], hv[39], hv[40], hv[41]};
  assign eth_src = {hv[6], hv[7], hv[8], hv[9], hv[10], hv[11]};
  assign ip_src  = {hv[26], hv[27], hv[28], hv[29]};
  assign ip_dst  = {hv[30], hv[31], hv[32], hv[33]};
  assign idv     = {hv[38], hv[39]};
  assign seqv    = {hv[40], hv[41]};

  assign is_arp  = (n >= 6'd42) && (eth == EthArp);
  assign is_icmp = (n >= 6'd62) && (eth == EthIpv4) && (hv[14][7:4] == 4'd4) &&
                   (hv[23] == 8'h01) && (ip_dst == own_ip_i);

  assign learn     = frame_end && (is_arp || is_icmp);
  assign learn_ip  = is_arp ? arp_sip : ip_src;
  assign learn_mac = is_arp ? arp_sha : eth_src;

  always_comb begin
    m_found  = 1'b0;
    f_found  = 1'b0;
    lk_found = 1'b0;
    m_idx    = '0;
    f_idx    = '0;
    lk_mac   = '0;
    for (int i = CacheEntries - 1; i >= 0; i--) begin
      if (cvalid_q[i] && cip_q[i] == learn_ip) begin
        m_found = 1'b1;
        m_idx   = IdxW'(i);
      end
      if (!cvalid_q[i]) begin
        f_found = 1'b1;
        f_idx   = IdxW'(i);
      end
      if (cvalid_q[i] && cip_q[i] == query_ip_i) begin
        lk_found = 1'b1;
        lk_mac   = cmac_q[i];
      end
    end
    slot = m_found ? m_idx : (f_found ? f_idx : '0);
  end

  always_comb begin
    kind = KIND_NONE;
    rpl  = RPL_NONE;
    if (is_arp) begin
      kind = KIND_ARP;
      if (arp_op == 16'd1 && arp_tip == own_ip_i) begin
        rpl = RPL_ARP;
      end
    end else if (is_icmp) begin
      if (hv[34] == 8'd8) begin
        kind = KIND_ECHO_REQ;
        rpl  = RPL_ECHO;
      end else if (hv[34] == 8'd0) begin
        kind = KIND_ECHO_RPL;
      end
    end
  end

  always_comb begin
    case (rpl)
      RPL_ARP:  mac_f = arp_sha;
      RPL_ECHO: mac_f = eth_src;
      default:  mac_f = '0;
    endcase
  end

  always_comb begin
    q_cmd_o = '0;
    if (is_op_lookup) begin
      q_cmd_o.reply = RPL_NONE;
      q_cmd_o.kind  = KIND_NONE;
      q_cmd_o.hit   = lk_found;
      q_cmd_o.mac   = lk_mac;
    end else begin
      q_cmd_o.reply    = rpl;
      q_cmd_o.kind     = kind;
      q_cmd_o.hit      = 1'b0;
      q_cmd_o.mac      = mac_f;
      q_cmd_o.peer_ip  = learn_ip;
      q_cmd_o.echo_id  = (kind == KIND_ECHO_RPL || kind == KIND_ECHO_REQ) ? idv  : '0;
      q_cmd_o.echo_seq = (kind == KIND_ECHO_RPL || kind == KIND_ECHO_REQ) ? seqv : '0;
      q_cmd_o.ip_ck    = ck_fold(IpHdrConst + {4'b0, own_ip_i[31:16]} +
                                 {4'b0, own_ip_i[15:0]} + {4'b0, ip_src[31:16]} +
                                 {4'b0, ip_src[15:0]});
      q_cmd_o.icmp_ck  = ck_fold(IcmpConst + {4'b0, idv} + {4'b0, seqv});
    end
  end

  assign q_push_o = accept_i && (is_op_lookup || rx_last_i);

  always_ff @(posedge clk_i) begin
    if (accept_i && !is_op_lookup) begin
      for (int i = 0; i < HdrLen; i++) begin
        if (byte_cnt_q == 6'(i)) begin
          hdr_q[i] <= rx_byte_i;
        end
      end
    end
    if (learn) begin
      cip_q[slot]  <= learn_ip;
      cmac_q[slot] <= learn_mac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      for (int i = 0; i < CacheEntries; i++) begin
        cvalid_q[i] <= 1'b0;
      end
    end else begin
      if (accept_i && !is_op_lookup) begin
        byte_cnt_q <= rx_last_i ? 6'd0 : n;
      end
      if (learn) begin
        cvalid_q[slot] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/aie_back.sv =====
// ----------------------------------------------------------------------------
// aie_back
// Turns queued commands into result items and builds reply frames byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module aie_back import aie_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  cmd_t  head_i,
  input  wire         q_empty_i,
  input  wire  [31:0] own_ip_i,
  input  wire  [47:0] own_mac_i,
  input  wire         pop_i,
  output logic        q_pop_o,
  output logic        empty_o,
  output res_t        res_o
);

  back_state_e state_q, state_d;
  logic [5:0]  idx_q, idx_d;
  logic        out_vld_q, load, out_free, last_b;
  res_t        res_q, res_d;
  logic [7:0]  tx_b;

  function automatic logic [7:0] rsel6(input logic [47:0] v, input logic [5:0] k);
    return v[8*(5 - k[2:0]) +: 8];
  endfunction

  always_comb begin
    tx_b = 8'h00;
    if (head_i.reply == RPL_ARP) begin
      case (idx_q)
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: tx_b = rsel6(head_i.mac, idx_q);
        6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11:
          tx_b = rsel6(own_mac_i, idx_q - 6'd6);
        6'd12: tx_b = 8'h08;
        6'd13: tx_b = 8'h06;
        6'd15: tx_b = 8'h01;
        6'd16: tx_b = 8'h08;
        6'd18: tx_b = 8'h06;
        6'd19: tx_b = 8'h04;
        6'd21: tx_b = 8'h02;
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27:
          tx_b = rsel6(own_mac_i, idx_q - 6'd22);
        6'd28: tx_b = own_ip_i[31:24];
        6'd29: tx_b = own_ip_i[23:16];
        6'd30: tx_b = own_ip_i[15:8];
        6'd31: tx_b = own_ip_i[7:0];
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37:
          tx_b = rsel6(head_i.mac, idx_q - 6'd32);
        6'd38: tx_b = head_i.peer_ip[31:24];
        6'd39: tx_b = head_i.peer_ip[23:16];
        6'd40: tx_b = head_i.peer_ip[15:8];
        6'd41: tx_b = head_i.peer_ip[7:0];
        default: tx_b = 8'h00;
      endcase
    end else begin
      case (idx_q)
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: tx_b = rsel6(head_i.mac, idx_q);
        6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11:
          tx_b = rsel6(own_mac_i, idx_q - 6'd6);
        6'd12: tx_b = 8'h08;
        6'd14: tx_b = 8'h45;
        6'd17: tx_b = 8'd48;
        6'd18: tx_b = 8'h12;
        6'd19: tx_b = 8'h34;
        6'd20: tx_b = 8'h40;
        6'd22: tx_b = 8'd64;
        6'd23: tx_b = 8'h01;
        6'd24: tx_b = head_i.ip_ck[15:8];
        6'd25: tx_b = head_i.ip_ck[7:0];
        6'd26: tx_b = own_ip_i[31:24];
        6'd27: tx_b = own_ip_i[23:16];
        6'd28: tx_b = own_ip_i[15:8];
        6'd29: tx_b = own_ip_i[7:0];
        6'd30: tx_b = head_i.peer_ip[31:24];
        6'd31: tx_b = head_i.peer_ip[23:16];
        6'd32: tx_b = head_i.peer_ip[15:8];
        6'd33: tx_b = head_i.peer_ip[7:0];
        6'd36: tx_b = head_i.icmp_ck[15:8];
        6'd37: tx_b = head_i.icmp_ck[7:0];
        6'd38: tx_b = head_i.echo_id[15:8];
        6'd39: tx_b = head_i.echo_id[7:0];
        6'd40: tx_b = head_i.echo_seq[15:8];
        6'd41: tx_b = head_i.echo_seq[7:0];
        default: tx_b = (idx_q >= 6'd42) ? 8'hA0 + {2'b0, idx_q - 6'd42} : 8'h00;
      endcase
    end
  end

  assign out_free = !out_vld_q || pop_i;
  assign last_b   = (head_i.reply == RPL_ARP) ? (idx_q == ArpLastIdx)
                                              : (idx_q == EchoLastIdx);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && out_free && head_i.reply != RPL_NONE) begin
          state_d = BK_SEND;
        end
      end
      BK_SEND: begin
        if (out_free && last_b) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    q_pop_o = 1'b0;
    idx_d   = idx_q;
    res_d   = '0;
    unique case (state_q)
      BK_IDLE: begin
        idx_d = '0;
        if (!q_empty_i && out_free && head_i.reply == RPL_NONE) begin
          load             = 1'b1;
          q_pop_o          = 1'b1;
          res_d.is_last    = 1'b1;
          res_d.frame_kind = head_i.kind;
          res_d.echo_id    = (head_i.kind == KIND_ECHO_RPL) ? head_i.echo_id  : '0;
          res_d.echo_seq   = (head_i.kind == KIND_ECHO_RPL) ? head_i.echo_seq : '0;
          res_d.lookup_hit = head_i.hit;
          res_d.lookup_mac = head_i.mac & {48{head_i.hit}};
        end
      end
      BK_SEND: begin
        if (out_free) begin
          load             = 1'b1;
          q_pop_o          = last_b;
          idx_d            = idx_q + 6'd1;
          res_d.tx_valid   = 1'b1;
          res_d.tx_byte    = tx_b;
          res_d.is_last    = last_b;
          res_d.frame_kind = head_i.kind;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty_o = !out_vld_q;
  assign res_o   = res_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("queue popped while empty");

  a_send_has_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SEND) |-> (!q_empty_i && head_i.reply != RPL_NONE))
    else $error("sending without a reply command at the queue head");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SEND) |-> (idx_q <= EchoLastIdx))
    else $error("reply byte index out of range");

endmodule

`default_nettype wire

// ===== tb/arp_icmp_echo_responder_tb.sv =====
// ----------------------------------------------------------------------------
// arp_icmp_echo_responder_tb
// Sends ARP and ICMP frames byte by byte, interleaved with cache lookups, and
// checks every reply byte, status item and lookup result against a predictor
// that keeps its own ARP cache, header store and address registers.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_icmp_echo_responder_tb import aie_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries = CacheEntriesDef;

  typedef struct packed {
    op_e         op;
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic [31:0] query_ip;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        opcode_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        rx_last_i = 1'b0;
  logic [31:0] query_ip_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        tx_valid_o;
  logic [7:0]  tx_byte_o;
  logic        is_last_o;
  logic [1:0]  frame_kind_o;
  logic [15:0] echo_id_o;
  logic [15:0] echo_seq_o;
  logic        lookup_hit_o;
  logic [47:0] lookup_mac_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  arp_icmp_echo_responder u_dut (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .rx_byte_i, .rx_last_i,
    .query_ip_i, .empty, .pop, .tx_valid_o, .tx_byte_o, .is_last_o,
    .frame_kind_o, .echo_id_o, .echo_seq_o, .lookup_hit_o, .lookup_mac_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  int          rx_count;
  logic [7:0]  hdr [HdrLen];
  logic        c_valid [Entries];
  logic [31:0] c_ip [Entries];
  logic [47:0] c_mac [Entries];

  item_t pending_items[$];
  res_t  expected_results[$];
  logic [7:0] no_bytes[];
  int    mismatches = 0;
  int    cycles = 0;
  bit    hold_off = 1'b1;
  int    burst_left = 0;
  int    gap_left = 0;
  int    stall_mode = 0;
  int    pop_phase = 0;

  function automatic logic [15:0] ones_sum(input logic [7:0] b[62], input int s, input int n);
    logic [31:0] acc;
    acc = 0;
    for (int i = 0; i < n; i += 2) acc += {b[s + i], b[s + i + 1]};
    while (acc >> 16) acc = (acc & 32'hFFFF) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  function automatic void learn_peer(input logic [31:0] ip, input logic [47:0] mac);
    int slot;
    slot = -1;
    for (int i = 0; i < Entries; i++) begin
      if (c_valid[i] && c_ip[i] == ip) begin
        c_mac[i] = mac;
        return;
      end
      if (!c_valid[i] && slot < 0) slot = i;
    end
    if (slot < 0) slot = 0;
    c_valid[slot] = 1'b1;
    c_ip[slot] = ip;
    c_mac[slot] = mac;
  endfunction

  function automatic void predict_responses(input item_t it);
    res_t r;
    logic [7:0] tx[62];
    int n, len;
    kind_e kind;
    logic [15:0] id, seq, ck;
    r = '0;
    r.is_last = 1'b1;
    if (it.op == OP_LOOKUP) begin
      for (int i = 0; i < Entries; i++)
        if (c_valid[i] && c_ip[i] == it.query_ip && !r.lookup_hit) begin
          r.lookup_hit = 1'b1;
          r.lookup_mac = c_mac[i];
        end
      expected_results.push_back(r);
      return;
    end
    if (rx_count < HdrLen) hdr[rx_count] = it.rx_byte;
    if (rx_count < 63) rx_count++;
    if (!it.rx_last) return;
    n = rx_count;
    rx_count = 0;
    kind = KIND_NONE;
    len = 0;
    id = 0;
    seq = 0;
    foreach (tx[i]) tx[i] = 8'h00;
    if (n >= 14) begin
      if ({hdr[12], hdr[13]} == EthArp && n >= 42) begin
        learn_peer({hdr[28], hdr[29], hdr[30], hdr[31]},
                   {hdr[22], hdr[23], hdr[24], hdr[25], hdr[26], hdr[27]});
        kind = KIND_ARP;
        if ({hdr[20], hdr[21]} == 16'd1 &&
            {hdr[38], hdr[39], hdr[40], hdr[41]} == own_ip_q) begin
          len = 42;
          for (int i = 0; i < 6; i++) begin
            tx[i] = hdr[22 + i];
            tx[6 + i] = own_mac_q[47 - 8*i -: 8];
            tx[22 + i] = own_mac_q[47 - 8*i -: 8];
            tx[32 + i] = hdr[22 + i];
          end
          {tx[12], tx[13], tx[14], tx[15]} = 32'h0806_0001;
          {tx[16], tx[17], tx[18], tx[19], tx[20], tx[21]} = 48'h0800_0604_0002;
          for (int i = 0; i < 4; i++) begin
            tx[28 + i] = own_ip_q[31 - 8*i -: 8];
            tx[38 + i] = hdr[28 + i];
          end
        end
      end else if ({hdr[12], hdr[13]} == EthIpv4 && n >= 62 && hdr[14][7:4] == 4'd4
                   && hdr[23] == 8'h01
                   && {hdr[30], hdr[31], hdr[32], hdr[33]} == own_ip_q) begin
        learn_peer({hdr[26], hdr[27], hdr[28], hdr[29]},
                   {hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]});
        if (hdr[34] == 8'd8) begin
          kind = KIND_ECHO_REQ;
          len = 62;
          for (int i = 0; i < 6; i++) begin
            tx[i] = hdr[6 + i];
            tx[6 + i] = own_mac_q[47 - 8*i -: 8];
          end
          tx[12] = 8'h08;
          tx[14] = 8'h45;
          tx[17] = 8'd48;
          tx[18] = 8'h12;
          tx[19] = 8'h34;
          tx[20] = 8'h40;
          tx[22] = 8'd64;
          tx[23] = 8'h01;
          for (int i = 0; i < 4; i++) begin
            tx[26 + i] = own_ip_q[31 - 8*i -: 8];
            tx[30 + i] = hdr[26 + i];
            tx[38 + i] = hdr[38 + i];
          end
          ck = ones_sum(tx, 14, 20);
          {tx[24], tx[25]} = ck;
          for (int i = 0; i < 20; i++) tx[42 + i] = 8'hA0 + 8'(i);
          ck = ones_sum(tx, 34, 28);
          {tx[36], tx[37]} = ck;
        end else if (hdr[34] == 8'd0) begin
          kind = KIND_ECHO_RPL;
          id = {hdr[38], hdr[39]};
          seq = {hdr[40], hdr[41]};
        end
      end
    end
    r.frame_kind = kind;
    if (len == 0) begin
      r.echo_id = id;
      r.echo_seq = seq;
      expected_results.push_back(r);
      return;
    end
    for (int i = 0; i < len; i++) begin
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = tx[i];
      r.is_last = (i == len - 1);
      r.frame_kind = kind;
      expected_results.push_back(r);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (push && !full) begin
      predict_responses(item_t'({opcode_i, rx_byte_i, rx_last_i, query_ip_i}));
      void'(pending_items.pop_front());
    end
    if ((push && !full) || !push) begin
      if (!hold_off && pending_items.size() > 0 && burst_left > 0) begin
        push <= 1'b1;
        opcode_i <= pending_items[0].op;
        rx_byte_i <= pending_items[0].rx_byte;
        rx_last_i <= pending_items[0].rx_last;
        query_ip_i <= pending_items[0].query_ip;
        burst_left <= burst_left - 1;
      end else begin
        push <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 80);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // consumer: stall pattern is chosen at random and changes over the run
  always @(posedge clk_i) begin
    res_t got, want;
    pop_phase <= pop_phase + 1;
    if (pop_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      2: pop <= (pop_phase % 8) < 3;
      default: pop <= ($urandom_range(0, 1) == 0);
    endcase
    if (rst_ni && pop && !empty) begin
      got = '{tx_valid_o, tx_byte_o, is_last_o, kind_e'(frame_kind_o), echo_id_o,
              echo_seq_o, lookup_hit_o, lookup_mac_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("arp_icmp_echo_responder_tb failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_address(input logic [31:0] ip, input logic [47:0] mac);
    apb_write(4'h0, {32'h0, ip});
    apb_write(4'h8, {16'h0, mac});
    own_ip_q = ip;
    own_mac_q = mac;
  endtask

  task automatic drain;
    hold_off = 1'b0;
    wait (pending_items.size() == 0 && !push);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    hold_off = 1'b1;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    pending_items.push_back('{OP_BYTE, b, last, $urandom});
  endtask

  task automatic add_lookup(input logic [31:0] ip);
    pending_items.push_back('{OP_LOOKUP, 8'($urandom), 1'($urandom), ip});
  endtask

  task automatic add_frame(input logic [7:0] f[], input int len);
    for (int i = 0; i < len; i++)
      add_byte((i < f.size()) ? f[i] : 8'($urandom), i == len - 1);
  endtask

  task automatic add_arp(input logic [15:0] op, input logic [31:0] sip,
                         input logic [47:0] smac, input logic [31:0] tip, input int len);
    logic [7:0] f[];
    f = new[42];
    foreach (f[i]) f[i] = $urandom;
    {f[12], f[13]} = EthArp;
    {f[20], f[21]} = op;
    for (int i = 0; i < 6; i++) f[22 + i] = smac[47 - 8*i -: 8];
    for (int i = 0; i < 4; i++) begin
      f[28 + i] = sip[31 - 8*i -: 8];
      f[38 + i] = tip[31 - 8*i -: 8];
    end
    add_frame(f, len);
  endtask

  task automatic add_icmp(input logic [7:0] icmp_type, input logic [31:0] sip,
                          input logic [31:0] dip, input logic [7:0] ver,
                          input logic [7:0] proto, input int len);
    logic [7:0] f[];
    f = new[42];
    foreach (f[i]) f[i] = $urandom;
    {f[12], f[13]} = EthIpv4;
    f[14] = ver;
    f[23] = proto;
    f[34] = icmp_type;
    for (int i = 0; i < 4; i++) begin
      f[26 + i] = sip[31 - 8*i -: 8];
      f[30 + i] = dip[31 - 8*i -: 8];
    end
    add_frame(f, len);
  endtask

  task automatic add_random_traffic(input int count);
    int start;
    logic [31:0] peer;
    start = pending_items.size();
    while (pending_items.size() - start < count) begin
      peer = ($urandom_range(0, 1) == 0) ? {24'h0A0002, 8'($urandom_range(0, 11))} : $urandom;
      case ($urandom_range(0, 9))
        0, 1: add_arp($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2)),
                      peer, {$urandom, 16'($urandom)},
                      $urandom_range(0, 3) == 0 ? $urandom : own_ip_q,
                      $urandom_range(0, 7) == 0 ? $urandom_range(14, 41)
                                                : $urandom_range(42, 70));
        2, 3, 4: add_icmp($urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1) * 8),
                          peer, $urandom_range(0, 5) == 0 ? $urandom : own_ip_q,
                          $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'h45,
                          $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'h01,
                          $urandom_range(0, 7) == 0 ? $urandom_range(14, 61)
                                                    : $urandom_range(62, 70));
        5, 6: add_lookup(peer);
        7: add_frame(no_bytes, $urandom_range(1, 13));
        default: begin
          for (int i = 0; i < $urandom_range(1, 70); i++)
            add_byte($urandom, $urandom_range(0, 40) == 0);
          add_byte($urandom, 1'b1);
        end
      endcase
    end
  endtask

  initial begin
    own_ip_q = OwnIpRst;
    own_mac_q = '0;
    rx_count = 0;
    no_bytes = new[0];
    foreach (c_valid[i]) c_valid[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset addresses, every frame kind, edges of the fields
    add_lookup(32'h0);
    add_arp(16'd1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, OwnIpRst, 42);
    add_icmp(8'd8, 32'h0000_0001, OwnIpRst, 8'h45, 8'h01, 62);
    add_icmp(8'd0, 32'h0000_0002, OwnIpRst, 8'h45, 8'h01, 63);
    add_icmp(8'd3, 32'h0000_0003, OwnIpRst, 8'h45, 8'h01, 62);
    add_arp(16'd2, 32'h0000_0000, 48'h0, 32'hFFFF_FFFF, 41);
    add_frame(no_bytes, 13);
    add_frame(no_bytes, 1);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h0000_0001);
    drain();

    set_address(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_arp(16'd1, 32'h1234_5678, 48'h0, 32'hFFFF_FFFF, 64);
    add_icmp(8'd8, 32'h0000_0000, 32'hFFFF_FFFF, 8'h4F, 8'h01, 80);
    add_random_traffic(20);
    drain();

    set_address(32'h0, 48'h0);
    add_random_traffic(20);
    drain();

    set_address($urandom, {$urandom, 16'($urandom)});
    add_random_traffic(20);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("arp_icmp_echo_responder_tb passed");
    end else begin
      $display("arp_icmp_echo_responder_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/aie_pkg.sv
sv/aie_fifo.sv
sv/aie_front.sv
sv/aie_back.sv
sv/arp_icmp_echo_responder.sv
tb/arp_icmp_echo_responder_tb.sv
